@@ design/rsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratio steering PD package
// Widths, fixed-point constants, register indexes and sequencer states shared
// by the ratio steering PD block.
// ----------------------------------------------------------------------------
package rsp_pkg;

  // Default sample width of the inductor samples.
  localparam int SAMPLE_BITS_DEF = 12;

  // Register and field widths.
  localparam int PGAIN_W    = 13;
  localparam int DGAIN_W    = 12;
  localparam int BASE_W     = 8;
  localparam int ERR_W      = 15;
  localparam int CORR_W     = 15;
  localparam int ANGLE_W    = 15;
  localparam int SPEED_W    = 9;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the configuration registers.
  localparam logic [PGAIN_W-1:0] PGAIN_RESET = 13'd3072;
  localparam logic [DGAIN_W-1:0] DGAIN_RESET = 12'd358;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd220;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd2;

  // Fixed-point constants: servo center and correction limit are 45 degrees
  // in Q8, and the speed coefficient is 0.0135 in Q24.
  localparam int SERVO_CENTER_Q8 = 11520;
  localparam int CORR_LIMIT_Q8   = 11520;
  localparam int DIFF_COEF_Q24   = 226492;
  localparam int DERIV_SHIFT     = 8;
  localparam int WHEEL_SHIFT     = 32;

  // Operand A width of the shared multiplier.
  localparam int MUL_A_W = 32;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_DIV_START,
    ST_DIV,
    ST_ERR,
    ST_MUL_D,
    ST_CORR,
    ST_MUL_K,
    ST_MUL_B,
    ST_SPEED
  } state_t;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ design/rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratio steering PD channels
// Valid/ready channels for the sample word and the result word.
// ----------------------------------------------------------------------------
interface rsp_in_if
  import rsp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface rsp_out_if
  import rsp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ANGLE_W-1:0]       servo_angle_q8;
  logic [SPEED_W-1:0]       left_speed;
  logic [SPEED_W-1:0]       right_speed;
  logic signed [CORR_W-1:0] correction_q8;
  logic                     zero_sum;

  modport source (
    output valid, output servo_angle_q8, output left_speed, output right_speed,
    output correction_q8, output zero_sum, input ready
  );
  modport sink (
    input valid, input servo_angle_q8, input left_speed, input right_speed,
    input correction_q8, input zero_sum, output ready
  );
endinterface

@@ design/rsp_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratio steering PD shared multiplier
// Unsigned multiplier with a registered product, used for every product.
// ----------------------------------------------------------------------------
module rsp_mul
  import rsp_pkg::*;
#(
  parameter int A_W = MUL_A_W,
  parameter int B_W = 16
) (
  input  logic             clk,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] prod
);

  // The product is taken every cycle; the sequencer picks the operands.
  always_ff @(posedge clk) begin
    prod <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

@@ design/rsp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratio steering PD divider
// Restoring divider that settles one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsp_div
  import rsp_pkg::*;
#(
  parameter int DIVIDEND_W = 25,
  parameter int DIVISOR_W  = 13,
  parameter int Q_W        = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [Q_W-1:0]        quotient,
  output div_status_t           status
);

  localparam int SH_W  = DIVISOR_W + Q_W - 1;
  localparam int CMP_W = (DIVIDEND_W > SH_W) ? DIVIDEND_W : SH_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CMP_W-1:0] rem;
  logic [CMP_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // Step counter and status. The caller keeps the quotient below 2^Q_W.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Compare and subtract the shifted divisor, most significant bit first.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= CMP_W'(dividend);
      dsr      <= CMP_W'(divisor) << (Q_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (rem >= dsr) begin
        rem      <= rem - dsr;
        quotient <= {quotient[Q_W-2:0], 1'b1};
      end else begin
        quotient <= {quotient[Q_W-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

@@ design/ratio_steering_pd_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratio steering PD unit
// Difference-over-sum PD steering: servo angle and wheel speeds from a pair
// of inductor samples, with a sequencer around one multiplier and a divider.
// ----------------------------------------------------------------------------
// A sample word runs the sequencer steps in order: proportional product,
// 13-step restoring division, error, derivative product, correction, then
// coefficient and base products; only then is a new one taken. A result word
// that still waits holds off the next sample word until it is taken.
// Reset: synchronous; gains and base speed return to their defaults and the
// previous error clears to zero. There is no clearing pass.
module ratio_steering_pd_unit
  import rsp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  rsp_in_if.sink                samples,
  rsp_out_if.source             results
);

  localparam int MUL_B_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = SAMPLE_BITS + 1;
  localparam int DIVD_W  = PGAIN_W + SAMPLE_BITS;
  localparam int DMAG_W  = DGAIN_W + ERR_W - 1 - DERIV_SHIFT;
  localparam int PSUM_W  = DMAG_W + 2;
  localparam logic signed [PSUM_W-1:0] LIM_P = PSUM_W'(CORR_LIMIT_Q8);
  localparam logic signed [PSUM_W-1:0] LIM_N = -PSUM_W'(CORR_LIMIT_Q8);

  // Configuration registers.
  logic [PGAIN_W-1:0] prop_gain;
  logic [DGAIN_W-1:0] deriv_gain;
  logic [BASE_W-1:0]  base_speed;

  // Sequencer.
  state_t state;
  state_t state_next;

  // Per-item working registers.
  logic [SUM_W-1:0]         sum;
  logic [SAMPLE_BITS-1:0]   abs_diff;
  logic                     diff_neg;
  logic                     zero;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  prev_err;
  logic [ERR_W-2:0]         abs_ed;
  logic                     ed_neg;
  logic signed [CORR_W-1:0] corr;
  logic [CORR_W-2:0]        abs_corr;
  logic                     corr_neg;

  // Output register.
  logic                     out_valid;
  logic [ANGLE_W-1:0]       out_angle;
  logic [SPEED_W-1:0]       out_left;
  logic [SPEED_W-1:0]       out_right;
  logic signed [CORR_W-1:0] out_corr;
  logic                     out_zero;

  // Shared units.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic               div_start;
  logic [PGAIN_W-1:0] quotient;
  div_status_t        div_status;

  logic accept;
  logic out_load;

  rsp_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rsp_div #(
    .DIVIDEND_W (DIVD_W),
    .DIVISOR_W  (SUM_W),
    .Q_W        (PGAIN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIVD_W-1:0]),
    .divisor  (sum),
    .quotient (quotient),
    .status   (div_status)
  );

  assign accept   = samples.valid && samples.ready;
  assign out_load = (state == ST_SPEED) && (!out_valid || results.ready);

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PGAIN_RESET;
      deriv_gain <= DGAIN_RESET;
      base_speed <= BASE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_PROP_GAIN:  prop_gain  <= wr_data[PGAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain <= wr_data[DGAIN_W-1:0];
        REG_BASE_SPEED: base_speed <= wr_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept) state_next = ST_MUL_P;
      ST_MUL_P:     state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV:       if (div_status.done) state_next = ST_ERR;
      ST_ERR:       state_next = ST_MUL_D;
      ST_MUL_D:     state_next = ST_CORR;
      ST_CORR:      state_next = ST_MUL_K;
      ST_MUL_K:     state_next = ST_MUL_B;
      ST_MUL_B:     state_next = ST_SPEED;
      ST_SPEED:     if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and operand selection. A new sample word is
  // taken only when the output register is free by the time it is needed, so
  // the wheel product never has to be held in the speed step.
  always_comb begin
    samples.ready = 1'b0;
    div_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state)
      ST_IDLE:      samples.ready = !out_valid || results.ready;
      ST_MUL_P: begin
        mul_a = MUL_A_W'(prop_gain);
        mul_b = MUL_B_W'(abs_diff);
      end
      ST_DIV_START: div_start = 1'b1;
      ST_MUL_D: begin
        mul_a = MUL_A_W'(abs_ed);
        mul_b = MUL_B_W'(deriv_gain);
      end
      ST_MUL_K: begin
        mul_a = MUL_A_W'(DIFF_COEF_Q24);
        mul_b = MUL_B_W'(abs_corr);
      end
      ST_MUL_B: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(base_speed);
      end
      default: ;
    endcase
  end

  // Sum and magnitude of the difference, taken with the sample word.
  always_ff @(posedge clk) begin
    if (accept) begin
      sum      <= SUM_W'(samples.left_sample) + SUM_W'(samples.right_sample);
      diff_neg <= samples.left_sample < samples.right_sample;
      zero     <= (samples.left_sample == '0) && (samples.right_sample == '0);
      if (samples.left_sample >= samples.right_sample) begin
        abs_diff <= samples.left_sample - samples.right_sample;
      end else begin
        abs_diff <= samples.right_sample - samples.left_sample;
      end
    end
  end

  // Signed error from the quotient; a zero sum forces it to zero.
  logic signed [ERR_W-1:0] err_val;
  logic signed [ERR_W-1:0] ed_val;
  logic signed [ERR_W-1:0] ed_abs;

  always_comb begin
    if (zero) begin
      err_val = '0;
    end else if (diff_neg) begin
      err_val = -$signed(ERR_W'(quotient));
    end else begin
      err_val = $signed(ERR_W'(quotient));
    end
    ed_val = err_val - prev_err;
    ed_abs = (ed_val < 0) ? -ed_val : ed_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (state == ST_ERR) begin
      prev_err <= err_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ERR) begin
      err    <= err_val;
      abs_ed <= ed_abs[ERR_W-2:0];
      ed_neg <= ed_val < 0;
    end
  end

  // Derivative term truncated toward zero, then the saturated correction.
  logic [DMAG_W-1:0]        dmag;
  logic signed [DMAG_W:0]   deriv_val;
  logic signed [PSUM_W-1:0] psum;
  logic signed [PSUM_W-1:0] corr_val;
  logic signed [PSUM_W-1:0] corr_abs;

  always_comb begin
    dmag = prod[DERIV_SHIFT +: DMAG_W];
    if (ed_neg) begin
      deriv_val = -$signed({1'b0, dmag});
    end else begin
      deriv_val = $signed({1'b0, dmag});
    end
    psum = PSUM_W'(err) + PSUM_W'(deriv_val);
    if (psum > LIM_P) begin
      corr_val = LIM_P;
    end else if (psum < LIM_N) begin
      corr_val = LIM_N;
    end else begin
      corr_val = psum;
    end
    corr_abs = (corr_val < 0) ? -corr_val : corr_val;
  end

  always_ff @(posedge clk) begin
    if (state == ST_CORR) begin
      corr     <= corr_val[CORR_W-1:0];
      abs_corr <= corr_abs[CORR_W-2:0];
      corr_neg <= corr_val < 0;
    end
  end

  // Wheel speeds from base * K * |correction| / 2^32.
  logic [BASE_W-1:0]  wheel_hi;
  logic               wheel_frac;
  logic [SPEED_W-1:0] speed_up;
  logic [SPEED_W-1:0] speed_dn;

  always_comb begin
    wheel_hi   = prod[WHEEL_SHIFT +: BASE_W];
    wheel_frac = |prod[WHEEL_SHIFT-1:0];
    speed_up   = SPEED_W'(base_speed) + SPEED_W'(wheel_hi);
    speed_dn   = SPEED_W'(base_speed) - SPEED_W'(wheel_hi) - SPEED_W'(wheel_frac);
  end

  // Output register; holds while the result word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle <= ANGLE_W'(SERVO_CENTER_Q8) + ANGLE_W'(corr);
      out_corr  <= corr;
      out_zero  <= zero;
      if (corr_neg) begin
        out_left  <= speed_up;
        out_right <= speed_dn;
      end else begin
        out_left  <= speed_dn;
        out_right <= speed_up;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.servo_angle_q8 = out_angle;
  assign results.left_speed     = out_left;
  assign results.right_speed    = out_right;
  assign results.correction_q8  = out_corr;
  assign results.zero_sum       = out_zero;

  // The stored error never leaves the range a 13-bit quotient allows.
  a_prev_err_range: assert property (@(posedge clk) disable iff (rst)
    (prev_err <= 15'sd8191) && (prev_err >= -15'sd8191))
    else $error("previous error out of range");

  // A zero sum must give a zero error before the derivative pass.
  a_zero_err: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_D) && zero |-> (err == '0))
    else $error("zero sum did not force a zero error");

  // The correction on the output stays saturated.
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (out_corr <= 15'sd11520) && (out_corr >= -15'sd11520))
    else $error("correction out of range");

  // Servo angle and correction agree.
  a_angle: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (out_angle == ANGLE_W'(ANGLE_W'(SERVO_CENTER_Q8) + ANGLE_W'(out_corr))))
    else $error("servo angle does not match correction");

  // The two wheel speeds straddle the base speed and sum to twice it, or one less.
  a_speed_pair: assert property (@(posedge clk) disable iff (rst)
    results.valid |->
      ((SPEED_W+1)'(out_left) + (SPEED_W+1)'(out_right) == (SPEED_W+1)'({base_speed, 1'b0})) ||
      ((SPEED_W+1)'(out_left) + (SPEED_W+1)'(out_right) + (SPEED_W+1)'(1)
        == (SPEED_W+1)'({base_speed, 1'b0})))
    else $error("wheel speeds do not balance");

endmodule

@@ dv/tb_ratio_steering_pd_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ratio steering PD unit testbench
// Drives sample words through the valid/ready channel with random gaps and
// result stalls, predicts every result word from its own fixed-point model of
// the difference-over-sum PD law, and compares each result field by field.
// The gains and base speed are changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_ratio_steering_pd_unit;
  import rsp_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam logic [SB-1:0] SAMPLE_MAX = '1;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [ANGLE_W-1:0]       servo_angle_q8;
    logic [SPEED_W-1:0]       left_speed;
    logic [SPEED_W-1:0]       right_speed;
    logic signed [CORR_W-1:0] correction_q8;
    logic                     zero_sum;
  } steer_word_t;

  // Steering predictor and store of expected result words.
  class steering_scoreboard;
    int prop_gain;
    int deriv_gain;
    int base_speed;
    longint last_error;
    steer_word_t expected_q[$];
    int errors;

    function new();
      prop_gain  = int'(PGAIN_RESET);
      deriv_gain = int'(DGAIN_RESET);
      base_speed = int'(BASE_RESET);
      last_error = 0;
      errors     = 0;
    endfunction

    // Registers keep only as many low bits as they are wide.
    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:  prop_gain  = int'(data[PGAIN_W-1:0]);
        REG_DERIV_GAIN: deriv_gain = int'(data[DGAIN_W-1:0]);
        REG_BASE_SPEED: base_speed = int'(data[BASE_W-1:0]);
        default: ;
      endcase
    endfunction

    // Wheel speed is base * (1 + term / 2^32), truncated; the factor stays positive.
    function longint wheel_speed(longint signed_term);
      longint factor;
      factor = (longint'(1) <<< WHEEL_SHIFT) + signed_term;
      return ((longint'(base_speed) * factor) >>> WHEEL_SHIFT) & 'h1FF;
    endfunction

    // Work out the result word for one accepted sample word.
    function void note_sample(logic [SB-1:0] l, logic [SB-1:0] r);
      longint left_v, right_v, total, err, dterm, corr, term;
      steer_word_t w;
      left_v  = longint'(l);
      right_v = longint'(r);
      total   = left_v + right_v;
      // A zero sum forces the error to zero; the derivative still runs.
      err = 0;
      if (total != 0) err = (longint'(prop_gain) * (left_v - right_v)) / total;
      dterm = (longint'(deriv_gain) * (err - last_error)) / (longint'(1) <<< DERIV_SHIFT);
      corr = err + dterm;
      if (corr > CORR_LIMIT_Q8) corr = CORR_LIMIT_Q8;
      else if (corr < -CORR_LIMIT_Q8) corr = -CORR_LIMIT_Q8;
      // The state keeps the error before saturation.
      last_error = err;
      term = longint'(DIFF_COEF_Q24) * corr;
      w.servo_angle_q8 = ANGLE_W'(longint'(SERVO_CENTER_Q8) + corr);
      w.left_speed     = SPEED_W'(wheel_speed(-term));
      w.right_speed    = SPEED_W'(wheel_speed(term));
      w.correction_q8  = CORR_W'(corr);
      w.zero_sum       = (total == 0);
      expected_q.push_back(w);
    endfunction

    // Compare one result word with the oldest expected word.
    function void check_result(steer_word_t got);
      steer_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word with none expected: servo_angle_q8 %0d", got.servo_angle_q8);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.servo_angle_q8 !== want.servo_angle_q8) begin
        $error("servo_angle_q8: expected %0d, got %0d", want.servo_angle_q8, got.servo_angle_q8);
        errors++;
      end
      if (got.left_speed !== want.left_speed) begin
        $error("left_speed: expected %0d, got %0d", want.left_speed, got.left_speed);
        errors++;
      end
      if (got.right_speed !== want.right_speed) begin
        $error("right_speed: expected %0d, got %0d", want.right_speed, got.right_speed);
        errors++;
      end
      if (got.correction_q8 !== want.correction_q8) begin
        $error("correction_q8: expected %0d, got %0d", want.correction_q8, got.correction_q8);
        errors++;
      end
      if (got.zero_sum !== want.zero_sum) begin
        $error("zero_sum: expected %0d, got %0d", want.zero_sum, got.zero_sum);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  rsp_in_if #(.SAMPLE_BITS(SB)) samples_ch ();
  rsp_out_if results_ch ();

  ratio_steering_pd_unit #(.SAMPLE_BITS(SB)) uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .samples  (samples_ch),
    .results  (results_ch)
  );

  steering_scoreboard steer_sb = new();
  bit idle_en = 1'b0;
  int idle_cycles = 0;
  logic [SB-1:0] walk_l = '0;
  logic [SB-1:0] walk_r = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (!idle_en) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Small random step of one sample, kept inside the sample range.
  function automatic logic [SB-1:0] drift(logic [SB-1:0] x);
    int v;
    v = int'(x);
    v = v + int'($urandom_range(0, 128)) - 64;
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    return SB'(v);
  endfunction

  // Random sample pair: slowly drifting track readings most often, plus extremes,
  // zero sums, near balance and plain noise.
  task automatic next_pair(output logic [SB-1:0] l, output logic [SB-1:0] r);
    int kind;
    kind = $urandom_range(0, 19);
    case (kind)
      0: begin
        l = '0;
        r = '0;
      end
      1: begin
        l = SB'($urandom);
        r = '0;
      end
      2: begin
        l = '0;
        r = SB'($urandom);
      end
      3, 4: begin
        l = SB'($urandom);
        r = l ^ SB'($urandom_range(0, 7));
      end
      5, 6: begin
        l = SB'($urandom_range(0, 15));
        r = SB'($urandom_range(0, 15));
      end
      7: begin
        l = ($urandom_range(0, 1) ? SAMPLE_MAX : '0) ^ SB'($urandom_range(0, 1));
        r = ($urandom_range(0, 1) ? SAMPLE_MAX : '0) ^ SB'($urandom_range(0, 1));
      end
      8, 9, 10, 11, 12, 13, 14: begin
        walk_l = drift(walk_l);
        walk_r = drift(walk_r);
        l = walk_l;
        r = walk_r;
      end
      default: begin
        l = SB'($urandom);
        r = SB'($urandom);
      end
    endcase
  endtask

  // Offer one sample word and wait until it is taken.
  task automatic send_sample(input logic [SB-1:0] l, input logic [SB-1:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_ch.valid        <= 1'b1;
    samples_ch.left_sample  <= l;
    samples_ch.right_sample <= r;
    do @(posedge clk); while (!(samples_ch.valid && samples_ch.ready));
    steer_sb.note_sample(l, r);
  endtask

  // Stop offering words and wait for every expected result word.
  task automatic drain();
    samples_ch.valid <= 1'b0;
    while (steer_sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    steer_sb.apply_write(idx, data);
  endtask

  // Write all registers, plus a stray write to the unused index.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] pg, input logic [CFG_DATA_W-1:0] dg,
                               input logic [CFG_DATA_W-1:0] base);
    put_reg(REG_PROP_GAIN, pg);
    put_reg(REG_DERIV_GAIN, dg);
    put_reg(REG_BASE_SPEED, base);
    put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int count, input bit quiet);
    logic [SB-1:0] l;
    logic [SB-1:0] r;
    idle_en = !quiet;
    repeat (count) begin
      next_pair(l, r);
      send_sample(l, r);
    end
    drain();
  endtask

  // Extremes, zero sums after a nonzero error, saturation both ways, balance,
  // and small odd ratios where division truncates toward zero.
  task automatic directed_words();
    idle_en = 1'b0;
    send_sample('0, '0);
    send_sample(SAMPLE_MAX, '0);
    send_sample('0, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, '0);
    send_sample('0, '0);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(12'd1, 12'd0);
    send_sample(12'd0, 12'd1);
    send_sample(12'd1, 12'd1);
    send_sample(SAMPLE_MAX, 12'd1);
    send_sample(12'd1, SAMPLE_MAX);
    send_sample(12'd2048, 12'd2047);
    send_sample(12'd2047, 12'd2048);
    send_sample(12'd3, 12'd1);
    send_sample(12'd1, 12'd3);
    send_sample('0, '0);
    send_sample('0, '0);
    send_sample(12'd100, 12'd300);
    send_sample(12'd300, 12'd100);
    send_sample(SAMPLE_MAX, 12'd4094);
    drain();
  endtask

  // Result side: check every accepted word, then stall at random.
  always @(posedge clk) begin : result_sink
    steer_word_t got;
    int stall_left;
    if (rst) begin
      results_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        got.servo_angle_q8 = results_ch.servo_angle_q8;
        got.left_speed     = results_ch.left_speed;
        got.right_speed    = results_ch.right_speed;
        got.correction_q8  = results_ch.correction_q8;
        got.zero_sum       = results_ch.zero_sum;
        steer_sb.check_result(got);
      end
      if (stall_left > 0) begin
        results_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        results_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed words, then random phases under several settings.
  initial begin
    rst                     <= 1'b1;
    wr_en                   <= 1'b0;
    wr_index                <= REG_PROP_GAIN;
    wr_data                 <= '0;
    samples_ch.valid        <= 1'b0;
    samples_ch.left_sample  <= '0;
    samples_ch.right_sample <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_words();
    run_phase(200, 1'b0);
    // All ones: every register at its top value after width masking.
    load_settings('1, '1, '1);
    run_phase(280, 1'b0);
    // All gains and speed zero; the speed write has only high bits set.
    load_settings('0, '0, 13'h1F00);
    run_phase(120, 1'b1);
    load_settings(13'd7936, '0, 13'd255);
    run_phase(220, 1'b0);
    load_settings('0, 13'd4095, 13'd1);
    run_phase(220, 1'b0);
    repeat (3) begin
      load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      run_phase(200, 1'b0);
    end
    load_settings(PGAIN_RESET, DGAIN_RESET, BASE_RESET);
    run_phase(180, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (steer_sb.errors == 0 && steer_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ ratio_steering_pd_unit.f @@
design/rsp_pkg.sv
design/rsp_if.sv
design/rsp_mul.sv
design/rsp_div.sv
design/ratio_steering_pd_unit.sv
dv/tb_ratio_steering_pd_unit.sv
